FILE: design/idbf_pkg.sv
// Shared types, frame layout constants and the CRC-32 byte step for the
// IMU delta burst framer. No dependencies.

package idbf_pkg;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BURST  = 1'b1;

    // Frame layout (wire order word indexes)
    localparam int unsigned FRAME_WORDS   = 20;
    localparam int unsigned PAYLOAD_WORDS = 15;
    localparam int unsigned WIDX_W        = $clog2(FRAME_WORDS);
    localparam int unsigned PIDX_W        = $clog2(PAYLOAD_WORDS);

    localparam logic [WIDX_W-1:0] W_DUMMY     = WIDX_W'(0);
    localparam logic [WIDX_W-1:0] W_ID_LAST   = WIDX_W'(2);
    localparam logic [WIDX_W-1:0] W_PAY_FIRST = WIDX_W'(3);
    localparam logic [WIDX_W-1:0] W_PAY_LAST  = WIDX_W'(17);
    localparam logic [WIDX_W-1:0] W_CRC_LO    = WIDX_W'(18);
    localparam logic [WIDX_W-1:0] W_CRC_HI    = WIDX_W'(19);

    // Payload word indexes
    localparam logic [PIDX_W-1:0] PAY_STATUS      = PIDX_W'(0);
    localparam logic [PIDX_W-1:0] PAY_TEMP        = PIDX_W'(1);
    localparam logic [PIDX_W-1:0] PAY_DELTA_FIRST = PIDX_W'(2);
    localparam logic [PIDX_W-1:0] PAY_DELTA_LAST  = PIDX_W'(13);
    localparam logic [PIDX_W-1:0] PAY_COUNT       = PIDX_W'(14);

    localparam logic [15:0] FRAME_ID    = 16'hC3C3;
    localparam logic [15:0] STATUS_WORD = 16'h0000;
    localparam logic [15:0] DUMMY_WORD  = 16'h0000;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    // Input transaction
    typedef struct packed {
        logic               kind;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] temp_word;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } t_out_item;

    // Command to the CRC unit
    typedef struct packed {
        logic       init;
        logic       en;
        logic [7:0] data;
    } t_crc_cmd;

    // Reflected CRC-32, one byte, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: design/idbf_crc_unit.sv
// Shared CRC-32 accumulator: one byte per enabled cycle.
// Depends on idbf_pkg.

module idbf_crc_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idbf_pkg::t_crc_cmd i_cmd,
    output logic [31:0]       o_crc
);
    import idbf_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    // next accumulator value
    always_comb begin
        n_crc = r_crc;
        if (i_cmd.init) begin
            n_crc = CRC_INIT;
        end else if (i_cmd.en) begin
            n_crc = crc_byte(r_crc, i_cmd.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: design/idbf_sample_store.sv
// Latest sample registers, sample counter and payload word read port.
// Y and Z deltas are kept already negated, in transmitted form. Depends on idbf_pkg.

module idbf_sample_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  idbf_pkg::t_in_item             i_item,
    input  logic [idbf_pkg::PIDX_W-1:0]    i_rd_idx,
    output logic [15:0]                    o_rd_word
);
    import idbf_pkg::*;

    logic [31:0] r_delta [6];
    logic [15:0] r_temp;
    logic [15:0] r_count;

    logic [PIDX_W-1:0] v_off;
    logic [2:0]        v_sel;
    logic [31:0]       v_delta;

    // store a sample, advance the wrapping counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_delta[i] <= '0;
            end
            r_temp  <= '0;
            r_count <= '0;
        end else if (i_we) begin
            r_delta[0] <= i_item.angle_x;
            r_delta[1] <= 32'd0 - i_item.angle_y;
            r_delta[2] <= 32'd0 - i_item.angle_z;
            r_delta[3] <= i_item.vel_x;
            r_delta[4] <= 32'd0 - i_item.vel_y;
            r_delta[5] <= 32'd0 - i_item.vel_z;
            r_temp     <= i_item.temp_word;
            r_count    <= r_count + 16'd1;
        end
    end

    // payload word select: deltas go low half then high half
    assign v_off   = i_rd_idx - PAY_DELTA_FIRST;
    assign v_sel   = v_off[PIDX_W-1:1];
    assign v_delta = (v_sel < 3'd6) ? r_delta[v_sel] : 32'd0;

    always_comb begin
        case (i_rd_idx)
            PAY_STATUS: o_rd_word = STATUS_WORD;
            PAY_TEMP:   o_rd_word = r_temp;
            PAY_COUNT:  o_rd_word = r_count;
            default: begin
                if (i_rd_idx >= PAY_DELTA_FIRST && i_rd_idx <= PAY_DELTA_LAST) begin
                    o_rd_word = v_off[0] ? v_delta[31:16] : v_delta[15:0];
                end else begin
                    o_rd_word = 16'd0;
                end
            end
        endcase
    end

endmodule

FILE: design/imu_delta_burst_crc32_framer.sv
// Top level of the IMU delta burst framer: word sequencer and output register.
// Depends on idbf_pkg, idbf_sample_store and idbf_crc_unit.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-------------------------
//   input   | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//   output  | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// A sample transaction is written to the sample store and gives no output.
// A burst transaction gives 20 words, each built in S_BUILD and held in the output
// register in S_SEND until it is taken.
// The shared byte-wide CRC unit takes the low byte of a payload word as it is built
// and the high byte in the next cycle. Output stalls simply extend the frame.
// Input is not ready from burst acceptance until the last word is taken.
// Synchronous active-low reset returns to idle with the CRC at all ones.

module imu_delta_burst_crc32_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  idbf_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output idbf_pkg::t_out_item  o_out_item
);
    import idbf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BUILD = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [WIDX_W-1:0] r_idx, n_idx;
    logic              r_hi_pend, n_hi_pend;
    logic [7:0]        r_hi_byte, n_hi_byte;
    t_out_item         r_out, n_out;

    logic              w_store_we;
    logic [PIDX_W-1:0] w_pidx;
    logic [15:0]       w_pay_word;
    logic [31:0]       w_crc;
    t_crc_cmd          w_crc_cmd;
    logic              w_in_fire;
    logic              w_out_fire;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = o_out_valid && i_out_ready;
    assign w_pidx     = PIDX_W'(r_idx - W_PAY_FIRST);

    idbf_sample_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_store_we),
        .i_item    (i_in_item),
        .i_rd_idx  (w_pidx),
        .o_rd_word (w_pay_word)
    );

    idbf_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_crc_cmd),
        .o_crc   (w_crc)
    );

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_hi_pend      = r_hi_pend;
        n_hi_byte      = r_hi_byte;
        n_out          = r_out;
        w_store_we     = 1'b0;
        w_crc_cmd.init = 1'b0;
        w_crc_cmd.en   = 1'b0;
        w_crc_cmd.data = 8'd0;
        o_in_ready     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_fire) begin
                    if (i_in_item.kind == KIND_SAMPLE) begin
                        w_store_we = 1'b1;
                    end else begin
                        n_state        = S_BUILD;
                        n_idx          = W_DUMMY;
                        w_crc_cmd.init = 1'b1;
                    end
                end
            end
            S_BUILD: begin
                n_state    = S_SEND;
                n_out.last = 1'b0;
                if (r_idx == W_DUMMY) begin
                    n_out.word = DUMMY_WORD;
                end else if (r_idx <= W_ID_LAST) begin
                    n_out.word = FRAME_ID;
                end else if (r_idx <= W_PAY_LAST) begin
                    n_out.word     = w_pay_word;
                    w_crc_cmd.en   = 1'b1;
                    w_crc_cmd.data = w_pay_word[7:0];
                    n_hi_pend      = 1'b1;
                    n_hi_byte      = w_pay_word[15:8];
                end else if (r_idx == W_CRC_LO) begin
                    n_out.word = ~w_crc[15:0];
                end else begin
                    n_out.word = ~w_crc[31:16];
                    n_out.last = 1'b1;
                end
            end
            S_SEND: begin
                // high byte of the payload word goes through the CRC first
                if (r_hi_pend) begin
                    w_crc_cmd.en   = 1'b1;
                    w_crc_cmd.data = r_hi_byte;
                    n_hi_pend      = 1'b0;
                end
                if (i_out_ready) begin
                    if (r_out.last) begin
                        n_state        = S_IDLE;
                        w_crc_cmd.init = 1'b1;
                    end else begin
                        n_state = S_BUILD;
                        n_idx   = r_idx + WIDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= W_DUMMY;
            r_hi_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_hi_pend <= n_hi_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hi_byte <= n_hi_byte;
        r_out     <= n_out;
    end

    assign o_out_valid = (r_state == S_SEND);
    assign o_out_item  = r_out;

    // no new input while a frame is in flight
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during frame");

    // a burst starts the frame at the dummy word
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_item.kind == KIND_BURST) |=> (r_state == S_BUILD && r_idx == W_DUMMY))
        else $error("burst did not start frame");

    // after the last word the block is idle with the CRC rearmed
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out_item.last) |=> (o_in_ready && w_crc == CRC_INIT))
        else $error("frame end did not return to idle");

    // last only ever marks the CRC high word
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (r_idx == W_CRC_HI && !r_hi_pend))
        else $error("last flag on wrong word");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for imu_delta_burst_crc32_framer: predicts every burst frame
// and its CRC-32 from the stored sample and compares each output word. Uses idbf_pkg.

module tb_top;
    import idbf_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int RANDOM_ITEMS = 460;

    // Predicts burst frames from the latest sample and checks the output words
    class burst_frame_checker;
        logic [31:0] held_delta [6];
        logic [15:0] held_temp;
        logic [15:0] held_count;
        t_out_item   expected_words [$];
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned samples_taken;
        int unsigned bursts_taken;

        function new();
            foreach (held_delta[i]) held_delta[i] = '0;
            held_temp     = '0;
            held_count    = '0;
            mismatches    = 0;
            words_checked = 0;
            samples_taken = 0;
            bursts_taken  = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Reflected CRC over one 16-bit word, low byte first == bit 0 first
        function logic [31:0] crc_word(logic [31:0] c, logic [15:0] w);
            logic [31:0] r;
            r = c ^ {16'h0000, w};
            for (int b = 0; b < 16; b++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void push_word(logic [15:0] w, logic is_last);
            t_out_item o;
            o.word = w;
            o.last = is_last;
            expected_words.push_back(o);
        endfunction

        // Accepted input transaction: store a sample or predict a whole frame
        function void note_input(t_in_item item);
            logic [15:0] pay [PAYLOAD_WORDS];
            logic [31:0] v;
            logic [31:0] crc;
            if (item.kind == KIND_SAMPLE) begin
                held_delta[0] = item.angle_x;
                held_delta[1] = item.angle_y;
                held_delta[2] = item.angle_z;
                held_delta[3] = item.vel_x;
                held_delta[4] = item.vel_y;
                held_delta[5] = item.vel_z;
                held_temp     = item.temp_word;
                held_count    = held_count + 16'd1;
                samples_taken++;
                return;
            end
            bursts_taken++;
            pay[0] = STATUS_WORD;
            pay[1] = held_temp;
            for (int i = 0; i < 6; i++) begin
                v = held_delta[i];
                // Y and Z axes go out negated, wrapping at 32 bits
                if (i == 1 || i == 2 || i == 4 || i == 5) v = -v;
                pay[2 + 2 * i] = v[15:0];
                pay[3 + 2 * i] = v[31:16];
            end
            pay[14] = held_count;
            crc = CRC_INIT;
            for (int i = 0; i < PAYLOAD_WORDS; i++) crc = crc_word(crc, pay[i]);
            crc = crc ^ CRC_INIT;
            push_word(DUMMY_WORD, 1'b0);
            push_word(FRAME_ID, 1'b0);
            push_word(FRAME_ID, 1'b0);
            for (int i = 0; i < PAYLOAD_WORDS; i++) push_word(pay[i], 1'b0);
            push_word(crc[15:0], 1'b0);
            push_word(crc[31:16], 1'b1);
        endfunction

        // Accepted output transaction against the oldest predicted word
        function void check_word(t_out_item got);
            t_out_item want;
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual word %h last %b",
                         $time, got.word, got.last);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.word !== want.word) begin
                mismatches++;
                $display("%0t: word mismatch: expected %h, actual %h",
                         $time, want.word, got.word);
            end
            if (got.last !== want.last) begin
                mismatches++;
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    bit calm = 1'b0;
    burst_frame_checker frames = new();

    imu_delta_burst_crc32_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure, off during calm stretches
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) frames.check_word(o_out_item);
    end

    // Values biased toward the extremes
    function automatic logic [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item(logic kind);
        t_in_item it;
        it.kind      = kind;
        it.angle_x   = pick32();
        it.angle_y   = pick32();
        it.angle_z   = pick32();
        it.vel_x     = pick32();
        it.vel_y     = pick32();
        it.vel_z     = pick32();
        it.temp_word = pick16();
        return it;
    endfunction

    function automatic t_in_item make_sample(logic [31:0] ax, logic [31:0] ay,
                                             logic [31:0] az, logic [31:0] vx,
                                             logic [31:0] vy, logic [31:0] vz,
                                             logic [15:0] t);
        t_in_item it;
        it.kind      = KIND_SAMPLE;
        it.angle_x   = ax;
        it.angle_y   = ay;
        it.angle_z   = az;
        it.vel_x     = vx;
        it.vel_y     = vy;
        it.vel_z     = vz;
        it.temp_word = t;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_item(input t_in_item item);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        frames.note_input(item);
        @(negedge i_clk);
    endtask

    // Hold the sender off until every predicted word has come out
    task automatic drain_frames();
        do begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end while (frames.pending() != 0);
    endtask

    initial begin
        t_in_item burst_junk;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: burst before any sample, with junk data that must be ignored
        burst_junk      = random_item(KIND_BURST);
        burst_junk.vel_z = 32'hFFFF_FFFF;
        drive_item(burst_junk);
        // Largest positive values
        drive_item(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF));
        drive_item(random_item(KIND_BURST));
        // Most negative values: negation wraps onto itself
        drive_item(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000));
        drive_item(random_item(KIND_BURST));
        // All ones
        drive_item(make_sample('1, '1, '1, '1, '1, '1, 16'hFFFF));
        drive_item(random_item(KIND_BURST));
        // All zeros
        drive_item(make_sample('0, '0, '0, '0, '0, '0, 16'h0000));
        drive_item(random_item(KIND_BURST));
        // Mixed pattern, then two bursts in a row from the same sample
        drive_item(make_sample(32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF,
                               32'h8765_4321, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5A5A));
        drive_item(random_item(KIND_BURST));
        drive_item(random_item(KIND_BURST));
        // Back-to-back samples, only the last one is framed
        drive_item(random_item(KIND_SAMPLE));
        drive_item(random_item(KIND_SAMPLE));
        drive_item(random_item(KIND_BURST));
        drain_frames();

        // Random mix with a calm stretch and two full drains
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 180 && n < 280);
            if (n == 100 || n == 300) drain_frames();
            drive_item(random_item(($urandom_range(99) < 45) ? KIND_BURST : KIND_SAMPLE));
        end

        // Closing bursts around fresh samples
        drive_item(random_item(KIND_BURST));
        drive_item(random_item(KIND_SAMPLE));
        drive_item(random_item(KIND_BURST));
        drive_item(random_item(KIND_SAMPLE));
        drive_item(random_item(KIND_BURST));

        i_in_valid <= 1'b0;
        while (frames.pending() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (frames.pending() != 0) frames.mismatches++;

        $display("Covered %0d sample and %0d burst transactions, %0d frame words checked,",
                 frames.samples_taken, frames.bursts_taken, frames.words_checked);
        $display("including field extremes, bursts before any sample and repeated bursts.");
        if (frames.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d words still outstanding", frames.pending());
        $display("Verification failed");
        $finish;
    end

endmodule
